// ===== design/btk_pkg.sv =====
// Shared types, constants and codes of the brightest star tile keeper.
`default_nettype none
package btk_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 33;
  localparam int CIDX_W  = 2;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_APPENDED = 3'd2;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FAINT    = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd5;
  localparam logic [STAT_W-1:0] ST_READ_MT  = 3'd6;

  localparam logic [CIDX_W-1:0] REG_RA_LOW   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RA_HIGH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DEC_LOW  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_DEC_HIGH = 2'd3;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [15:0] mag;
    logic [31:0]        ra;
    logic signed [31:0] dec;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_clear;
    logic scan_step;
    logic read_issue;
    logic set_read;
    logic set_read_empty;
    logic set_outside;
    logic decide;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_read;
    logic slot_ok;
    logic window_ok;
    logic list_empty;
    logic scan_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/btk_ctrl.sv =====
// Controller state machine of the brightest star tile keeper.
`default_nettype none
module btk_ctrl
  import btk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_clear = 1'b1;
        if (sts.op_read) begin
          if (sts.slot_ok) begin
            cmd.read_issue = 1'b1;
            state_nxt = S_READ;
          end else begin
            cmd.set_read_empty = 1'b1;
            state_nxt = S_FINISH;
          end
        end else if (!sts.window_ok) begin
          cmd.set_outside = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.list_empty) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_FINISH;
      end
      S_READ: begin
        cmd.set_read = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/btk_dp.sv =====
// Datapath of the brightest star tile keeper: registers, star list memory and compares.
`default_nettype none
module btk_dp
  import btk_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic                cfg_we,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                in_op,
  input  wire logic [31:0]         in_star_ra,
  input  wire logic signed [31:0]  in_star_dec,
  input  wire logic signed [15:0]  in_star_mag,
  input  wire logic [31:0]         in_star_id,
  input  wire logic [SLOT_W-1:0]   in_read_slot,
  output logic [STAT_W-1:0]        out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [COUNT_W-1:0]       out_count,
  output logic [31:0]              out_id,
  output logic signed [15:0]       out_mag,
  output logic [31:0]              out_ra,
  output logic signed [31:0]       out_dec
);

  // Window bounds.
  logic [CFG_W-1:0]   ra_low_r, ra_high_r;
  logic signed [31:0] dec_low_r, dec_high_r;

  // Captured item.
  logic              op_r;
  entry_t            item_r;
  logic [SLOT_W-1:0] rslot_r;

  // Star list.
  entry_t            mem [CAPACITY];
  entry_t            rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_r;
  logic              scan_issue;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              dup_r;
  logic              worst_first_r;
  entry_t            worst_r;
  logic [IDX_W-1:0]  worst_idx_r;

  // Result waiting for the output register, and the output register itself.
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  entry_t            res_entry_r, res_entry_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [COUNT_W-1:0] out_count_r;
  entry_t            out_entry_r;

  logic              full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_low_r   <= '0;
      ra_high_r  <= 33'h1_0000_0000;
      dec_low_r  <= 32'shC000_0000;
      dec_high_r <= 32'sh4000_0001;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RA_LOW:   ra_low_r   <= cfg_data;
        REG_RA_HIGH:  ra_high_r  <= cfg_data;
        REG_DEC_LOW:  dec_low_r  <= cfg_data[31:0];
        REG_DEC_HIGH: dec_high_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_op;
      item_r.id  <= in_star_id;
      item_r.mag <= in_star_mag;
      item_r.ra  <= in_star_ra;
      item_r.dec <= in_star_dec;
      rslot_r    <= in_read_slot;
    end
  end

  assign full = (count_r >= CNT_W'(CAPACITY));

  assign sts.op_read    = (op_r == OP_READ);
  assign sts.slot_ok    = (32'(rslot_r) < 32'(count_r)) && (32'(rslot_r) < 32'(CAPACITY));
  assign sts.window_ok  = ({1'b0, item_r.ra} >= ra_low_r) && ({1'b0, item_r.ra} < ra_high_r)
                          && (item_r.dec >= dec_low_r) && (item_r.dec < dec_high_r);
  assign sts.list_empty = (count_r == '0);
  assign sts.scan_last  = rd_vld_r && ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r);

  // One read port: the scan walks the list, a read item fetches its slot.
  assign scan_issue = cmd.scan_step && (scan_r < count_r);
  assign rd_en      = scan_issue || cmd.read_issue;
  assign rd_addr    = cmd.read_issue ? IDX_W'(rslot_r) : scan_r[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    if (cmd.decide && !dup_r) begin
      if (!full) begin
        wr_en = 1'b1;
      end else if (item_r.mag < worst_r.mag) begin
        wr_en   = 1'b1;
        wr_addr = worst_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Scan bookkeeping: duplicate flag and faintest entry, first of equals kept.
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_r        <= '0;
      rd_vld_r      <= 1'b0;
      dup_r         <= 1'b0;
      worst_first_r <= 1'b1;
    end else if (cmd.scan_step) begin
      rd_vld_r <= scan_issue;
      rd_idx_r <= scan_r[IDX_W-1:0];
      if (scan_issue) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        if (rd_data_r.id == item_r.id) begin
          dup_r <= 1'b1;
        end
        if (worst_first_r || (rd_data_r.mag > worst_r.mag)) begin
          worst_r     <= rd_data_r;
          worst_idx_r <= rd_idx_r;
        end
        worst_first_r <= 1'b0;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.decide && !dup_r && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_entry_nxt  = res_entry_r;
    if (cmd.set_outside) begin
      res_status_nxt = ST_OUTSIDE;
      res_slot_nxt   = '0;
      res_entry_nxt  = '0;
    end else if (cmd.set_read_empty) begin
      res_status_nxt = ST_READ_MT;
      res_slot_nxt   = rslot_r;
      res_entry_nxt  = '0;
    end else if (cmd.set_read) begin
      res_status_nxt = ST_READ_OK;
      res_slot_nxt   = rslot_r;
      res_entry_nxt  = rd_data_r;
    end else if (cmd.decide) begin
      res_slot_nxt  = '0;
      res_entry_nxt = '0;
      if (dup_r) begin
        res_status_nxt = ST_DUP;
      end else if (!full) begin
        res_status_nxt = ST_APPENDED;
        res_slot_nxt   = SLOT_W'(count_r);
      end else if (item_r.mag < worst_r.mag) begin
        res_status_nxt = ST_REPLACED;
        res_slot_nxt   = SLOT_W'(worst_idx_r);
        res_entry_nxt  = worst_r;
      end else begin
        res_status_nxt = ST_FAINT;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_entry_r  <= res_entry_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_count_r  <= COUNT_W'(count_r);
      out_entry_r  <= res_entry_r;
    end
  end

  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;
  assign out_id     = out_entry_r.id;
  assign out_mag    = out_entry_r.mag;
  assign out_ra     = out_entry_r.ra;
  assign out_dec    = out_entry_r.dec;

endmodule
`default_nettype wire

// ===== design/brightest_star_tile_keeper.sv =====
// Top level of the brightest star tile keeper.
//
// The block keeps the brightest stars of one sky tile in a list of CAPACITY
// (sixteen) entries. An offered item is rejected when its right ascension or
// declination lies outside the half-open window set by the four configuration
// registers, or when its catalog name is already held. Otherwise it is appended
// while there is room; once the list is full it replaces the faintest entry
// (largest magnitude, lowest slot among equals) only when it is strictly
// brighter, and the evicted star is reported. A read item returns one stored
// entry, or reports an empty slot. Every item gives exactly one result item.
// An offer that passes the window searches the list for a duplicate and the
// faintest entry, walking the list memory through its single read port, one
// entry per cycle; with an empty list there is no search. A read item fetches
// its slot through the same port, and a rejected offer reads nothing. A result
// that is still waiting holds the block in its final step. A new item is taken
// while the previous result still waits in the output register.
// The list memory needs no clearing after reset: only slots below the fill
// count are ever read. Configuration writes take effect at once and are meant
// for times when the block is idle.
`default_nettype none
module brightest_star_tile_keeper
  import btk_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_op,
  input  wire logic [31:0]         in_star_ra,
  input  wire logic signed [31:0]  in_star_dec,
  input  wire logic signed [15:0]  in_star_mag,
  input  wire logic [31:0]         in_star_id,
  input  wire logic [SLOT_W-1:0]   in_read_slot,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [COUNT_W-1:0]       out_count,
  output logic [31:0]              out_id,
  output logic signed [15:0]       out_mag,
  output logic [31:0]              out_ra,
  output logic signed [31:0]       out_dec
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item; the datapath holds all payload.
  btk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  btk_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_op        (in_op),
    .in_star_ra   (in_star_ra),
    .in_star_dec  (in_star_dec),
    .in_star_mag  (in_star_mag),
    .in_star_id   (in_star_id),
    .in_read_slot (in_read_slot),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .out_count    (out_count),
    .out_id       (out_id),
    .out_mag      (out_mag),
    .out_ra       (out_ra),
    .out_dec      (out_dec)
  );

endmodule
`default_nettype wire

// ===== design/btk_checker.sv =====
// Port-level assertions of the brightest star tile keeper and their binding.
`default_nettype none
module btk_checker
  import btk_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STAT_W-1:0]   out_status,
  input wire logic [SLOT_W-1:0]   out_slot,
  input wire logic [COUNT_W-1:0]  out_count,
  input wire logic [31:0]         out_id,
  input wire logic signed [15:0]  out_mag,
  input wire logic [31:0]         out_ra,
  input wire logic signed [31:0]  out_dec
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id))
    else $error("result changed while stalled");

  // The list never holds more than its capacity.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_count) <= 32'(CAPACITY))
    else $error("count beyond capacity");

  // An appended star lands in the last held slot.
  a_append_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_APPENDED |-> out_count == COUNT_W'(out_slot) + COUNT_W'(1))
    else $error("appended slot does not match count");

  // Rejections and empty reads carry no star.
  a_no_star: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OUTSIDE || out_status == ST_DUP ||
                  out_status == ST_FAINT || out_status == ST_READ_MT)
      |-> out_id == '0 && out_mag == '0 && out_ra == '0 && out_dec == '0)
    else $error("star fields not zero");

  // A replacement only happens on a full list.
  a_replace_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_REPLACED |-> 32'(out_count) == 32'(CAPACITY))
    else $error("replacement on a list that is not full");

endmodule

bind brightest_star_tile_keeper btk_checker u_btk_checker (.*);
`default_nettype wire

// ===== tb/sv/star_list_checker.sv =====
// Checker that predicts and compares every result item of the brightest star tile keeper.
`timescale 1ns / 100ps
module star_list_checker
  import btk_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_op,
  input  logic [31:0]              in_star_ra,
  input  logic signed [31:0]       in_star_dec,
  input  logic signed [15:0]       in_star_mag,
  input  logic [31:0]              in_star_id,
  input  logic [SLOT_W-1:0]        in_read_slot,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STAT_W-1:0]        out_status,
  input  logic [SLOT_W-1:0]        out_slot,
  input  logic [COUNT_W-1:0]       out_count,
  input  logic [31:0]              out_id,
  input  logic signed [15:0]       out_mag,
  input  logic [31:0]              out_ra,
  input  logic signed [31:0]       out_dec,
  output int unsigned              fail_count,
  output int unsigned              outstanding
);

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic [31:0]        id;
    logic signed [15:0] mag;
    logic [31:0]        ra;
    logic signed [31:0] dec;
  } tile_result_t;

  logic [CFG_W-1:0]   win_ra_lo;
  logic [CFG_W-1:0]   win_ra_hi;
  logic signed [31:0] win_dec_lo;
  logic signed [31:0] win_dec_hi;
  entry_t             held [CAPACITY];
  int                 fill;
  tile_result_t       expected_q [$];

  // Applies one item to the mirrored star list and returns the result it must give.
  function automatic tile_result_t keep_star(input logic op, input logic [31:0] s_ra,
                                             input logic signed [31:0] s_dec,
                                             input logic signed [15:0] s_mag,
                                             input logic [31:0] s_id,
                                             input logic [SLOT_W-1:0] rslot);
    tile_result_t r;
    logic         known;
    int           faintest;
    r = '0;
    if (op == OP_READ) begin
      r.slot = rslot;
      if (int'(rslot) < fill) begin
        r.status = ST_READ_OK;
        r.id     = held[rslot].id;
        r.mag    = held[rslot].mag;
        r.ra     = held[rslot].ra;
        r.dec    = held[rslot].dec;
      end else begin
        r.status = ST_READ_MT;
      end
    end else if (!({1'b0, s_ra} >= win_ra_lo && {1'b0, s_ra} < win_ra_hi &&
                   s_dec >= win_dec_lo && s_dec < win_dec_hi)) begin
      r.status = ST_OUTSIDE;
    end else begin
      known = 1'b0;
      for (int i = 0; i < fill; i++)
        if (held[i].id == s_id) known = 1'b1;
      if (known) begin
        r.status = ST_DUP;
      end else if (fill < CAPACITY) begin
        r.status   = ST_APPENDED;
        r.slot     = SLOT_W'(fill);
        held[fill] = '{id: s_id, mag: s_mag, ra: s_ra, dec: s_dec};
        fill++;
      end else begin
        // Faintest is the largest magnitude; a strict compare keeps the lowest slot on ties.
        faintest = 0;
        for (int i = 1; i < CAPACITY; i++)
          if ($signed(held[i].mag) > $signed(held[faintest].mag)) faintest = i;
        if (s_mag < $signed(held[faintest].mag)) begin
          r.status       = ST_REPLACED;
          r.slot         = SLOT_W'(faintest);
          r.id           = held[faintest].id;
          r.mag          = held[faintest].mag;
          r.ra           = held[faintest].ra;
          r.dec          = held[faintest].dec;
          held[faintest] = '{id: s_id, mag: s_mag, ra: s_ra, dec: s_dec};
        end else begin
          r.status = ST_FAINT;
        end
      end
    end
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  task automatic report(input string why, input tile_result_t want, input tile_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected status=%0d slot=%0d count=%0d id=%h mag=%0d ra=%h dec=%0d",
               $time, why, want.status, want.slot, want.count, want.id, want.mag, want.ra,
               want.dec);
      $display("%0t %s:      got status=%0d slot=%0d count=%0d id=%h mag=%0d ra=%h dec=%0d",
               $time, why, got.status, got.slot, got.count, got.id, got.mag, got.ra, got.dec);
    end
  endtask

  always @(posedge clk) begin : watch
    tile_result_t want;
    tile_result_t got;
    if (!rst_n) begin
      win_ra_lo  = 33'h0_0000_0000;
      win_ra_hi  = 33'h1_0000_0000;
      win_dec_lo = 32'shC000_0000;
      win_dec_hi = 32'sh4000_0001;
      fill       = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RA_LOW:   win_ra_lo  = cfg_data;
          REG_RA_HIGH:  win_ra_hi  = cfg_data;
          REG_DEC_LOW:  win_dec_lo = cfg_data[31:0];
          REG_DEC_HIGH: win_dec_hi = cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_status, out_slot, out_count, out_id, out_mag, out_ra, out_dec};
        if (expected_q.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.count !== want.count || got.id !== want.id || got.mag !== want.mag ||
              got.ra !== want.ra || got.dec !== want.dec)
            report("mismatch", want, got);
        end
      end
      if (in_valid && in_ready)
        expected_q = {expected_q, keep_star(in_op, in_star_ra, in_star_dec, in_star_mag,
                                            in_star_id, in_read_slot)};
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== tb/sv/tb_brightest_star_tile_keeper.sv =====
// Testbench top of the brightest star tile keeper: stimulus, window settings and verdict.
`timescale 1ns / 100ps
module tb_brightest_star_tile_keeper;
  import btk_pkg::*;

  // A full turn of right ascension and a quarter turn of declination.
  localparam longint TURN        = 64'sd1 << 32;
  localparam longint QUARTER     = 64'sd1 << 30;
  // The limit leaves a wide margin over the worst correct run.
  localparam int     CYCLE_LIMIT = 400000;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CIDX_W-1:0]     cfg_index    = REG_RA_LOW;
  logic [CFG_W-1:0]      cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic                  in_op        = OP_OFFER;
  logic [31:0]           in_star_ra   = '0;
  logic signed [31:0]    in_star_dec  = '0;
  logic signed [15:0]    in_star_mag  = '0;
  logic [31:0]           in_star_id   = '0;
  logic [SLOT_W-1:0]     in_read_slot = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [STAT_W-1:0]     out_status;
  logic [SLOT_W-1:0]     out_slot;
  logic [COUNT_W-1:0]    out_count;
  logic [31:0]           out_id;
  logic signed [15:0]    out_mag;
  logic [31:0]           out_ra;
  logic signed [31:0]    out_dec;

  int unsigned           fail_count;
  int unsigned           outstanding;
  int unsigned           cycle_count  = 0;

  // When set, neither the sender nor the receiver inserts idle cycles.
  logic                  steady       = 1'b0;

  // Copy of the window last written, used to aim stars at it and at its edges.
  longint                w_ra_lo;
  longint                w_ra_hi;
  longint                w_dec_lo;
  longint                w_dec_hi;

  // Magnitudes drift brighter over the run, so that a full list keeps seeing
  // stars that are brighter than its faintest entry and replacements go on.
  int                    bright_level = 0;

  // Recently offered catalog names, reused to provoke duplicates.
  logic [31:0]           id_pool [$];

  brightest_star_tile_keeper dut (.*);

  star_list_checker list_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, 28 times in a hundred, outside the steady stretch.
  always @(negedge clk)
    out_ready <= steady || ($urandom_range(0, 99) >= 28);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Picks a right ascension: mostly inside the window, sometimes on or just past
  // either bound, sometimes anywhere at all.
  function automatic logic [31:0] pick_ra();
    longint v;
    case ($urandom_range(0, 15))
      0:       v = w_ra_lo;
      1:       v = w_ra_hi - 1;
      2:       v = w_ra_hi;
      3:       v = w_ra_lo - 1;
      4:       v = longint'($urandom);
      default: v = (w_ra_hi > w_ra_lo) ? w_ra_lo + longint'($urandom) % (w_ra_hi - w_ra_lo)
                                       : longint'($urandom);
    endcase
    return v[31:0];
  endfunction

  // Same for declination, kept within the legal range of plus or minus a quarter turn.
  function automatic logic signed [31:0] pick_dec();
    longint v;
    case ($urandom_range(0, 15))
      0:       v = w_dec_lo;
      1:       v = w_dec_hi - 1;
      2:       v = w_dec_hi;
      3:       v = w_dec_lo - 1;
      4:       v = -QUARTER + longint'($urandom_range(0, 32'h8000_0000));
      default: v = (w_dec_hi > w_dec_lo)
                   ? w_dec_lo + longint'($urandom) % (w_dec_hi - w_dec_lo)
                   : -QUARTER + longint'($urandom_range(0, 32'h8000_0000));
    endcase
    if (v < -QUARTER) v = -QUARTER;
    if (v > QUARTER) v = QUARTER;
    return v[31:0];
  endfunction

  // Presents one item and holds it until the block takes it. The task starts and
  // ends at a falling edge, so valid stays high between back-to-back items.
  task automatic send_item(input logic op, input logic [31:0] ra,
                           input logic signed [31:0] dec, input logic signed [15:0] mag,
                           input logic [31:0] id, input logic [SLOT_W-1:0] rslot);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_star_ra   <= ra;
    in_star_dec  <= dec;
    in_star_mag  <= mag;
    in_star_id   <= id;
    in_read_slot <= rslot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Offer a star; the unused slot field carries random bits.
  task automatic offer(input logic [31:0] ra, input logic signed [31:0] dec,
                       input logic signed [15:0] mag, input logic [31:0] id);
    id_pool = {id_pool, id};
    if (id_pool.size() > 40) void'(id_pool.pop_front());
    send_item(OP_OFFER, ra, dec, mag, id, SLOT_W'($urandom_range(0, 15)));
  endtask

  // Read one slot; the unused star fields carry random bits.
  task automatic query_slot(input logic [SLOT_W-1:0] rslot);
    send_item(OP_READ, $urandom, pick_dec(), 16'($urandom), $urandom, rslot);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] index, input longint value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
  endtask

  // Writes all four bounds on consecutive cycles. Only called while the block is idle.
  task automatic write_window(input longint ra_lo, input longint ra_hi,
                              input longint dec_lo, input longint dec_hi);
    w_ra_lo  = ra_lo;
    w_ra_hi  = ra_hi;
    w_dec_lo = dec_lo;
    w_dec_hi = dec_hi;
    write_reg(REG_RA_LOW, ra_lo);
    write_reg(REG_RA_HIGH, ra_hi);
    write_reg(REG_DEC_LOW, dec_lo);
    write_reg(REG_DEC_HIGH, dec_hi);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A random window of random size. Now and then the upper right ascension bound is
  // drawn on its own, which can give an inverted window.
  task automatic random_window();
    longint ra_lo;
    longint ra_hi;
    longint dec_lo;
    longint dec_hi;
    ra_lo = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom);
    ra_hi = ra_lo + (longint'($urandom) >> $urandom_range(0, 24));
    if (ra_hi > TURN) ra_hi = TURN;
    if ($urandom_range(0, 7) == 0) ra_hi = longint'($urandom);
    dec_lo = -QUARTER + longint'($urandom_range(0, 32'h8000_0000));
    dec_hi = dec_lo + (longint'($urandom_range(0, 32'h8000_0001)) >> $urandom_range(0, 20));
    if (dec_hi > QUARTER + 1) dec_hi = QUARTER + 1;
    write_window(ra_lo, ra_hi, dec_lo, dec_hi);
  endtask

  // Holds off the sender until every result item is back, then lets the clock run
  // on with the block idle before any register is touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One random item: about a fifth are reads, the rest are offers. A quarter of the
  // offers reuse a recent name. Magnitudes mostly sit near the drifting level, on a
  // coarse grid now and then so that equal magnitudes occur, and a few span the
  // whole range.
  task automatic random_item();
    logic [31:0]        id;
    logic signed [15:0] mag;
    int                 v;
    if ($urandom_range(0, 99) < 20) begin
      query_slot(SLOT_W'($urandom_range(0, 15)));
    end else begin
      id = (id_pool.size() > 0 && $urandom_range(0, 3) == 0)
           ? id_pool[$urandom_range(0, id_pool.size() - 1)] : $urandom;
      if ($urandom_range(0, 15) == 0) begin
        mag = 16'($urandom);
      end else begin
        if ($urandom_range(0, 3) == 0)
          v = bright_level + 256 * (int'($urandom_range(0, 4)) - 2);
        else
          v = bright_level + int'($urandom_range(0, 1200)) - 600;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        mag = 16'(v);
      end
      if (bright_level > -31000) bright_level = bright_level - 30;
      offer(pick_ra(), pick_dec(), mag, id);
    end
  endtask

  initial begin : stimulus
    int n;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The reset values, written explicitly: full right ascension, and declination
    // from minus a quarter turn up to and including plus a quarter turn.
    write_window(0, TURN, -QUARTER, QUARTER + 1);

    // Directed part. Reading an empty list, then two stars on the extreme corners
    // of the window with the faintest magnitude, and a duplicate of the first.
    query_slot(0);
    offer(32'h0000_0000, 32'shC000_0000, 16'sh7FFF, 32'h0000_0000);
    offer(32'hFFFF_FFFF, 32'sh4000_0000, 16'sh7FFF, 32'hFFFF_FFFF);
    offer($urandom, pick_dec(), -16'sd5, 32'h0000_0000);
    query_slot(1);
    query_slot(2);
    // Fill the list. The brightest possible magnitude goes in, as do several equal ones.
    for (int k = 0; k < 14; k++)
      offer($urandom, pick_dec(), 16'((k == 0) ? -32768 : (k % 3 == 0) ? 100 : -200 * k),
            32'(k + 1));
    // The list is full. A star as faint as the faintest entry is turned away; the
    // two equal faintest entries are then evicted in slot order; a fainter star is
    // turned away.
    offer($urandom, pick_dec(), 16'sh7FFF, 32'd100);
    offer($urandom, pick_dec(), 16'sd0, 32'd101);
    offer($urandom, pick_dec(), 16'sd0, 32'd102);
    offer($urandom, pick_dec(), 16'sd5000, 32'd103);
    query_slot(15);
    settle();

    // Random phases, each under its own window. Phase 0 is the stretch without idling.
    for (int ph = 0; ph < 12; ph++) begin
      steady <= (ph == 0);
      n = 140;
      case (ph)
        1: begin
          write_window(64'h8000_0000, 64'h8000_1000, -1000, 1000);
          n = 110;
        end
        2: begin
          // Lower bound at a full turn: nothing can pass.
          write_window(TURN, TURN, -QUARTER, QUARTER + 1);
          n = 40;
        end
        3: begin
          // Inverted right ascension window rejects every star.
          write_window(64'h9000_0000, 64'h1000_0000, -QUARTER, QUARTER + 1);
          n = 40;
        end
        4: begin
          // Only stars exactly at plus a quarter turn pass.
          write_window(0, TURN, QUARTER, QUARTER + 1);
          n = 60;
        end
        5: begin
          // Both bounds at their lowest: an empty window.
          write_window(0, 0, -QUARTER, -QUARTER);
          n = 30;
        end
        11: begin
          write_window(0, TURN, -QUARTER, QUARTER + 1);
          n = 110;
        end
        default: random_window();
      endcase
      repeat (n) random_item();
      settle();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
